### rtl/core/efr_pkg.sv
package efr_pkg;

  localparam int BUFFER_DEPTH = 256;
  localparam int WPOS_W = $clog2(BUFFER_DEPTH + 1);
  localparam int POSITION_W = 9;
  localparam int BYTE_W = 8;
  localparam int BUSY_W = 2;
  localparam int PRESCALE_W = 5;

  localparam logic [BYTE_W-1:0] ESCAPE_BYTE = 8'h5C;
  localparam logic [PRESCALE_W-1:0] PRESCALE_FIRST = 5'd30;
  localparam logic [PRESCALE_W-1:0] PRESCALE_RELOAD = 5'd6;
  localparam logic [BUSY_W-1:0] BUSY_START = 2'd3;

  localparam logic [BYTE_W-1:0] START_CODE_RESET = 8'd0;
  localparam logic [BYTE_W-1:0] STOP_CODE_RESET = 8'd1;

  typedef enum logic [1:0] {
    OP_LINE_BYTE = 2'd0,
    OP_RELEASE   = 2'd1,
    OP_TICK      = 2'd2
  } op_t;

  typedef enum logic {
    KIND_DATA      = 1'b0,
    KIND_FRAME_END = 1'b1
  } kind_t;

  typedef enum logic {
    REG_START_CODE = 1'b0,
    REG_STOP_CODE  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                  escape_pending;
    logic [WPOS_W-1:0]     write_position;
    logic [BUSY_W-1:0]     busy_countdown;
    logic                  receiver_on;
    logic [PRESCALE_W-1:0] tick_prescale;
  } efr_state_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [BYTE_W-1:0] line_byte;
    logic              line_error;
    logic              tx_pending;
  } efr_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] stop_code;
  } efr_cfg_t;

  typedef struct packed {
    logic                  valid;
    logic                  kind;
    logic [POSITION_W-1:0] position;
    logic [BYTE_W-1:0]     payload;
  } efr_result_t;

endpackage

### rtl/core/escaped_frame_receiver_unit.sv
// Deframer for a backslash-escaped byte bus. One transaction (line byte,
// release or timer tick) is taken per clock; its result, if any, appears
// in the output register in the next cycle. The only stall comes from that
// output register: in_ready is low while a result is held and out_ready is
// low. start_code (address 0) and stop_code (address 4) are written over
// the APB port and should be changed only while the block is idle.
module escaped_frame_receiver_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [efr_pkg::BYTE_W-1:0]     line_byte,
  input  logic                          line_error,
  input  logic                          tx_pending,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          kind,
  output logic [efr_pkg::POSITION_W-1:0] position,
  output logic [efr_pkg::BYTE_W-1:0]     payload,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  efr_pkg::efr_state_t  state;
  efr_pkg::efr_state_t  state_next;
  efr_pkg::efr_item_t   item;
  efr_pkg::efr_cfg_t    cfg;
  efr_pkg::efr_result_t step_result;

  logic in_accept;
  logic cfg_write;
  logic reg_sel;

  assign item.operation = operation;
  assign item.line_byte = line_byte;
  assign item.line_error = line_error;
  assign item.tx_pending = tx_pending;

  assign in_ready = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  efr_step u_efr_step (
    .state      (state),
    .item       (item),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (step_result)
  );

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      efr_pkg::REG_START_CODE: prdata[efr_pkg::BYTE_W-1:0] = cfg.start_code;
      efr_pkg::REG_STOP_CODE:  prdata[efr_pkg::BYTE_W-1:0] = cfg.stop_code;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_code <= efr_pkg::START_CODE_RESET;
      cfg.stop_code <= efr_pkg::STOP_CODE_RESET;
    end else if (cfg_write) begin
      if (reg_sel == efr_pkg::REG_START_CODE) begin
        cfg.start_code <= pwdata[efr_pkg::BYTE_W-1:0];
      end else begin
        cfg.stop_code <= pwdata[efr_pkg::BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.escape_pending <= 1'b0;
      state.write_position <= '0;
      state.busy_countdown <= '0;
      state.receiver_on <= 1'b1;
      state.tick_prescale <= efr_pkg::PRESCALE_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        state <= state_next;
        out_valid <= step_result.valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk) begin
    if (in_accept && step_result.valid) begin
      kind <= step_result.kind;
      position <= step_result.position;
      payload <= step_result.payload;
    end
  end

endmodule

### rtl/core/efr_step.sv
module efr_step (
  input  efr_pkg::efr_state_t  state,
  input  efr_pkg::efr_item_t   item,
  input  efr_pkg::efr_cfg_t    cfg,
  output efr_pkg::efr_state_t  state_next,
  output efr_pkg::efr_result_t result
);

  logic do_store;
  logic byte_taken;

  assign byte_taken = !item.line_error && state.receiver_on && !item.tx_pending;

  always_comb begin
    state_next = state;
    do_store = 1'b0;
    result.valid = 1'b0;
    result.kind = efr_pkg::KIND_DATA;
    result.position = '0;
    result.payload = '0;

    unique case (item.operation)
      efr_pkg::OP_RELEASE: begin
        if (!item.tx_pending) begin
          state_next.receiver_on = 1'b1;
        end
      end
      efr_pkg::OP_TICK: begin
        if (state.tick_prescale == '0) begin
          if (state.busy_countdown != '0) begin
            state_next.busy_countdown = state.busy_countdown - 1'b1;
          end
          state_next.tick_prescale = efr_pkg::PRESCALE_RELOAD;
        end else begin
          state_next.tick_prescale = state.tick_prescale - 1'b1;
        end
      end
      efr_pkg::OP_LINE_BYTE: begin
        if (byte_taken) begin
          if (state.escape_pending) begin
            state_next.escape_pending = 1'b0;
            // start code wins over stop code and literal backslash
            priority if (item.line_byte == cfg.start_code) begin
              state_next.write_position = '0;
              state_next.busy_countdown = efr_pkg::BUSY_START;
            end else if (item.line_byte == cfg.stop_code) begin
              if (state.busy_countdown != '0) begin
                state_next.receiver_on = 1'b0;
                result.valid = 1'b1;
                result.kind = efr_pkg::KIND_FRAME_END;
                result.position = efr_pkg::POSITION_W'(state.write_position);
              end
              state_next.busy_countdown = '0;
            end else if (item.line_byte == efr_pkg::ESCAPE_BYTE) begin
              do_store = 1'b1;
            end else begin
              do_store = 1'b0;
            end
          end else if (item.line_byte == efr_pkg::ESCAPE_BYTE) begin
            state_next.escape_pending = 1'b1;
          end else begin
            do_store = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    // drop data once the buffer is full
    if (do_store &&
        (state.write_position < efr_pkg::WPOS_W'(efr_pkg::BUFFER_DEPTH))) begin
      state_next.write_position = state.write_position + 1'b1;
      result.valid = 1'b1;
      result.kind = efr_pkg::KIND_DATA;
      result.position = efr_pkg::POSITION_W'(state.write_position);
      result.payload = item.line_byte;
    end
  end

endmodule

### rtl/core/efr_checker.sv
module efr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [1:0]                    operation,
  input logic                          line_error,
  input logic                          tx_pending,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          kind,
  input logic [efr_pkg::POSITION_W-1:0] position,
  input logic [efr_pkg::BYTE_W-1:0]     payload
);

  // held result keeps its payload until the transaction completes
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(position)
      && $stable(payload))
    else $error("held result changed before it was taken");

  // a transaction that can never produce a result leaves the output empty
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (operation != efr_pkg::OP_LINE_BYTE || line_error
      || tx_pending) |=> !out_valid)
    else $error("result produced by a transaction that should give none");

  // no result right after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // stored bytes always land inside the buffer
  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == efr_pkg::KIND_DATA
      |-> position < efr_pkg::POSITION_W'(efr_pkg::BUFFER_DEPTH))
    else $error("data position beyond buffer end");

endmodule

bind escaped_frame_receiver_unit efr_checker u_efr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .operation  (operation),
  .line_error (line_error),
  .tx_pending (tx_pending),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .kind       (kind),
  .position   (position),
  .payload    (payload)
);

### bench/tb_escaped_frame_receiver_unit.sv
`timescale 1ns / 100ps

module tb_escaped_frame_receiver_unit;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_ITEMS = 130;
  localparam int PHASES = 7;

  typedef struct packed {
    efr_pkg::kind_t                 kind;
    logic [efr_pkg::POSITION_W-1:0] position;
    logic [efr_pkg::BYTE_W-1:0]     payload;
  } rx_result_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [1:0]                     operation = efr_pkg::OP_LINE_BYTE;
  logic [efr_pkg::BYTE_W-1:0]     line_byte = '0;
  logic                           line_error = 1'b0;
  logic                           tx_pending = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           kind;
  logic [efr_pkg::POSITION_W-1:0] position;
  logic [efr_pkg::BYTE_W-1:0]     payload;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [2:0]                     paddr = '0;
  logic [31:0]                    pwdata = '0;
  logic [31:0]                    prdata;
  logic                           pready;

  escaped_frame_receiver_unit dut (.*);

  always #6 clk = ~clk;

  efr_pkg::efr_item_t line_queue[$];
  rx_result_t         expected_rx[$];
  efr_pkg::efr_item_t head_item;
  bit         calm = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         idle_cycles = 0;
  int         queued_count = 0;
  int         accepted_count = 0;
  int         results_seen = 0;
  int         frames_closed = 0;
  int         full_drops = 0;
  int         mismatch_count = 0;

  // deframer state as the block should hold it
  logic                           rx_escape;
  logic [efr_pkg::WPOS_W-1:0]     rx_wr_pos;
  logic [efr_pkg::BUSY_W-1:0]     rx_busy;
  logic                           rx_enabled;
  logic [efr_pkg::PRESCALE_W-1:0] rx_prescale;
  logic [efr_pkg::BYTE_W-1:0]     rx_start_code = efr_pkg::START_CODE_RESET;
  logic [efr_pkg::BYTE_W-1:0]     rx_stop_code = efr_pkg::STOP_CODE_RESET;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic store_rx_byte(input logic [efr_pkg::BYTE_W-1:0] value);
    if (rx_wr_pos < efr_pkg::BUFFER_DEPTH) begin
      expected_rx.push_back('{efr_pkg::KIND_DATA, rx_wr_pos, value});
      rx_wr_pos = rx_wr_pos + 1'b1;
    end else begin
      full_drops++;
    end
  endtask

  task automatic predict_deframe(input efr_pkg::efr_item_t it);
    case (it.operation)
      efr_pkg::OP_RELEASE: begin
        if (!it.tx_pending) rx_enabled = 1'b1;
      end
      efr_pkg::OP_TICK: begin
        if (rx_prescale == 0) begin
          if (rx_busy != 0) rx_busy = rx_busy - 1'b1;
          rx_prescale = efr_pkg::PRESCALE_RELOAD;
        end else begin
          rx_prescale = rx_prescale - 1'b1;
        end
      end
      efr_pkg::OP_LINE_BYTE: begin
        if (!it.line_error && rx_enabled && !it.tx_pending) begin
          if (rx_escape) begin
            rx_escape = 1'b0;
            // start code takes priority over stop code and literal backslash
            if (it.line_byte == rx_start_code) begin
              rx_wr_pos = '0;
              rx_busy = efr_pkg::BUSY_START;
            end else if (it.line_byte == rx_stop_code) begin
              if (rx_busy != 0) begin
                rx_enabled = 1'b0;
                expected_rx.push_back('{efr_pkg::KIND_FRAME_END, rx_wr_pos, 8'h00});
              end
              rx_busy = '0;
            end else if (it.line_byte == efr_pkg::ESCAPE_BYTE) begin
              store_rx_byte(it.line_byte);
            end
          end else if (it.line_byte == efr_pkg::ESCAPE_BYTE) begin
            rx_escape = 1'b1;
          end else begin
            store_rx_byte(it.line_byte);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_item(input logic [1:0] op, input logic [efr_pkg::BYTE_W-1:0] value,
                            input logic err, input logic txp);
    line_queue.push_back('{op, value, err, txp});
    queued_count++;
  endtask

  task automatic queue_line(input logic [efr_pkg::BYTE_W-1:0] value);
    queue_item(efr_pkg::OP_LINE_BYTE, value, 1'b0, 1'b0);
  endtask

  task automatic queue_noise();
    case ($urandom_range(0, 4))
      0: queue_item(efr_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      1: queue_item(efr_pkg::OP_LINE_BYTE, 8'($urandom_range(0, 255)), 1'b1,
                    1'($urandom_range(0, 1)));
      2: queue_item(efr_pkg::OP_LINE_BYTE, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
      3: queue_item(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      default: queue_item(efr_pkg::OP_RELEASE, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endcase
  endtask

  task automatic queue_frame(input int n_data, input bit plain_end);
    int ending;
    ending = plain_end ? 0 : $urandom_range(0, 9);
    queue_line(efr_pkg::ESCAPE_BYTE);
    queue_line(rx_start_code);
    for (int i = 0; i < n_data; i++) begin
      case ($urandom_range(0, 24))
        0: queue_noise();
        1: begin
          queue_line(efr_pkg::ESCAPE_BYTE);
          queue_line(efr_pkg::ESCAPE_BYTE);
        end
        default: queue_line(8'($urandom_range(0, 255)));
      endcase
    end
    // ending 9 leaves the frame open, the next start restarts it
    if (ending != 9) begin
      if (ending == 8) begin
        queue_line(efr_pkg::ESCAPE_BYTE);
        queue_line(8'($urandom_range(0, 255)));
      end
      // enough ticks to run the busy countdown out before the stop
      if (ending == 7) begin
        repeat ($urandom_range(40, 60))
          queue_item(efr_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      queue_line(efr_pkg::ESCAPE_BYTE);
      queue_line(rx_stop_code);
      if ($urandom_range(0, 3) == 0) queue_line(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) == 0)
        queue_item(efr_pkg::OP_RELEASE, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'b1);
      queue_item(efr_pkg::OP_RELEASE, 8'($urandom_range(0, 255)),
                 1'($urandom_range(0, 1)), 1'b0);
    end
  endtask

  task automatic wait_idle();
    while (line_queue.size() != 0 || in_valid || expected_rx.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_code(input efr_pkg::reg_index_t idx,
                            input logic [efr_pkg::BYTE_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == efr_pkg::REG_START_CODE) rx_start_code = value;
    else rx_stop_code = value;
    // read back right after the write
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[efr_pkg::BYTE_W-1:0] !== value)
      report_mismatch($sformatf("register %0d reads %02h, wrote %02h", idx,
                                prdata[efr_pkg::BYTE_W-1:0], value));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (line_queue.size() != 0) begin
        head_item = line_queue.pop_front();
        operation <= head_item.operation;
        line_byte <= head_item.line_byte;
        line_error <= head_item.line_error;
        tx_pending <= head_item.tx_pending;
        in_valid <= 1'b1;
        gap_left <= calm ? 0 : pick_idle();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= calm ? 0 : pick_idle();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rx_escape = 1'b0;
      rx_wr_pos = '0;
      rx_busy = '0;
      rx_enabled = 1'b1;
      rx_prescale = efr_pkg::PRESCALE_FIRST;
      rx_start_code = efr_pkg::START_CODE_RESET;
      rx_stop_code = efr_pkg::STOP_CODE_RESET;
    end else begin
      if (in_valid && in_ready) begin
        accepted_count++;
        predict_deframe('{operation, line_byte, line_error, tx_pending});
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (kind == efr_pkg::KIND_FRAME_END) frames_closed++;
        if (expected_rx.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction kind %0d position %0d payload %02h",
                                    kind, position, payload));
        end else begin
          rx_result_t want;
          want = expected_rx.pop_front();
          if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
          if (position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d", position, want.position));
          if (payload !== want.payload)
            report_mismatch($sformatf("payload %02h, expected %02h", payload, want.payload));
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [efr_pkg::BYTE_W-1:0] code_a;
    logic [efr_pkg::BYTE_W-1:0] code_b;
    int phase_start;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, reset codes: start 00, stop 01
    queue_item(OP_UNUSED, 8'hFF, 1'b1, 1'b1);
    queue_item(efr_pkg::OP_TICK, 8'h00, 1'b0, 1'b0);
    queue_line(8'h00);
    queue_line(8'hFF);
    queue_item(efr_pkg::OP_LINE_BYTE, efr_pkg::ESCAPE_BYTE, 1'b1, 1'b0);
    queue_item(efr_pkg::OP_LINE_BYTE, 8'h12, 1'b0, 1'b1);
    queue_line(efr_pkg::ESCAPE_BYTE);
    queue_line(efr_pkg::STOP_CODE_RESET);
    queue_line(efr_pkg::ESCAPE_BYTE);
    queue_line(efr_pkg::START_CODE_RESET);
    queue_line(efr_pkg::ESCAPE_BYTE);
    queue_line(efr_pkg::ESCAPE_BYTE);
    queue_line(efr_pkg::ESCAPE_BYTE);
    queue_line(8'h77);
    // escape survives a byte ignored for a pending transmit
    queue_line(efr_pkg::ESCAPE_BYTE);
    queue_item(efr_pkg::OP_LINE_BYTE, efr_pkg::STOP_CODE_RESET, 1'b0, 1'b1);
    queue_line(efr_pkg::STOP_CODE_RESET);
    queue_line(8'hAA);
    queue_item(efr_pkg::OP_RELEASE, 8'h00, 1'b0, 1'b1);
    queue_line(8'hAB);
    queue_item(efr_pkg::OP_RELEASE, 8'h00, 1'b0, 1'b0);
    // empty frame
    queue_line(efr_pkg::ESCAPE_BYTE);
    queue_line(efr_pkg::START_CODE_RESET);
    queue_line(efr_pkg::ESCAPE_BYTE);
    queue_line(efr_pkg::STOP_CODE_RESET);
    queue_item(efr_pkg::OP_RELEASE, 8'hFF, 1'b1, 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          code_a = efr_pkg::START_CODE_RESET;
          code_b = efr_pkg::STOP_CODE_RESET;
        end
        1: begin
          code_a = 8'hFF;
          code_b = 8'h00;
        end
        2: begin
          code_a = 8'h00;
          code_b = 8'hFF;
        end
        3: begin
          code_a = efr_pkg::ESCAPE_BYTE;
          code_b = 8'h7E;
        end
        4: begin
          code_a = 8'h3A;
          code_b = efr_pkg::ESCAPE_BYTE;
        end
        5: begin
          code_a = 8'($urandom_range(0, 255));
          code_b = code_a;
        end
        default: begin
          code_a = 8'($urandom_range(0, 255));
          code_b = 8'($urandom_range(0, 255));
        end
      endcase
      wait_idle();
      write_code(efr_pkg::REG_START_CODE, code_a);
      write_code(efr_pkg::REG_STOP_CODE, code_b);
      calm = (phase == 2);
      phase_start = queued_count;
      // overruns the buffer, so the frame length reaches full depth
      if (phase == 1) queue_frame(300, 1'b1);
      while (queued_count - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 3) == 0) queue_noise();
        queue_frame(($urandom_range(0, 6) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(0, 12), 1'b0);
      end
    end

    wait_idle();
    if (expected_rx.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_rx.size()));
    $display("%0d transactions in, %0d results checked, %0d frames closed",
             accepted_count, results_seen, frames_closed);
    $display("%0d code settings, %0d bytes dropped on a full buffer", PHASES, full_drops);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/efr_pkg.sv
rtl/core/efr_step.sv
rtl/core/escaped_frame_receiver_unit.sv
rtl/core/efr_checker.sv
bench/tb_escaped_frame_receiver_unit.sv
